// ----- hw/rtl/ehcr_pkg.sv -----
// Shared types, constants and field helpers for the echo handshake command receiver.
// No dependencies; used by echo_handshake_command_receiver_core.
package ehcr_pkg;

   localparam int MSG_DEPTH_DEF = 16;
   // characters that the command fields ever look at
   localparam int FIELD_CHARS   = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CFG_START_CODE      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_ACK_CODE        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_RELEASE_CODE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_TYPE_BRIGHTNESS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_TYPE_COLOR      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_TYPE_SPEED      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CFG_TYPE_ANIMATION  = 3'd6;

   localparam logic [7:0] RST_START_CODE      = 8'd2;
   localparam logic [7:0] RST_ACK_CODE        = 8'd6;
   localparam logic [7:0] RST_RELEASE_CODE    = 8'd4;
   localparam logic [3:0] RST_TYPE_BRIGHTNESS = 4'd1;
   localparam logic [3:0] RST_TYPE_COLOR      = 4'd2;
   localparam logic [3:0] RST_TYPE_SPEED      = 4'd3;
   localparam logic [3:0] RST_TYPE_ANIMATION  = 4'd4;

   localparam logic [1:0] KIND_BRIGHTNESS = 2'd0;
   localparam logic [1:0] KIND_COLOR      = 2'd1;
   localparam logic [1:0] KIND_SPEED      = 2'd2;
   localparam logic [1:0] KIND_ANIMATION  = 2'd3;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_READ  = 2'd1,
      PH_WRITE = 2'd2,
      PH_ACK   = 2'd3
   } phase_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic logic [3:0] digit_val(input logic [7:0] c);
      logic [7:0] d;
      d = c - CHAR_ZERO;
      return d[3:0];
   endfunction

   // Leading-digit decimal value of up to three characters; v* marks chars inside the message.
   function automatic logic [9:0] field_val(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic v0,
                                            input logic v1, input logic v2);
      logic       ok0;
      logic       ok1;
      logic       ok2;
      logic [9:0] d0;
      logic [9:0] d1;
      logic [9:0] d2;
      logic [9:0] r;
      ok0 = v0 && is_digit(c0);
      ok1 = ok0 && v1 && is_digit(c1);
      ok2 = ok1 && v2 && is_digit(c2);
      d0  = {6'd0, digit_val(c0)};
      d1  = {6'd0, digit_val(c1)};
      d2  = {6'd0, digit_val(c2)};
      if (ok2) begin
         r = d0 * 10'd100 + d1 * 10'd10 + d2;
      end else if (ok1) begin
         r = d0 * 10'd10 + d1;
      end else if (ok0) begin
         r = d0;
      end else begin
         r = 10'd0;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/echo_handshake_command_receiver_core.sv -----
// Echo handshake command receiver: echoes bytes, collects the message, decodes commands.
// Depends on ehcr_pkg.
// A word accepted at req_* passes the input register, then the result register, to rsp_*.
// Throughput: one word per cycle unless rsp_ready stalls; both registers run as one pass.
// Reset (synchronous, active high): phase read, held char and message length zero,
//   configuration registers at their defaults; message characters are not cleared.
module echo_handshake_command_receiver_core #(
   parameter int MSG_DEPTH = ehcr_pkg::MSG_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_echo_valid,
   output logic [7:0]                      rsp_echo_byte,
   output logic                            rsp_cmd_valid,
   output logic [1:0]                      rsp_cmd_kind,
   output logic [9:0]                      rsp_value_a,
   output logic [9:0]                      rsp_value_b,
   output logic [9:0]                      rsp_value_c,
   output logic [9:0]                      rsp_value_d,
   input  logic                            csr_write_en,
   input  logic [ehcr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ehcr_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int LEN_W = $clog2(MSG_DEPTH + 1);
   localparam int NCH   = ehcr_pkg::FIELD_CHARS;

   // configuration
   logic [7:0] start_code_ff;
   logic [7:0] ack_code_ff;
   logic [7:0] release_code_ff;
   logic [3:0] type_bright_ff;
   logic [3:0] type_color_ff;
   logic [3:0] type_speed_ff;
   logic [3:0] type_anim_ff;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       advance;

   // block state
   ehcr_pkg::phase_type phase_ff;
   ehcr_pkg::phase_type phase_in;
   logic [7:0]          held_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [7:0]          msg_ff [NCH];

   // actions
   logic       hold_en;
   logic       append_en;
   logic       clear_en;
   logic       decode_en;
   logic       echo_v_in;
   logic [7:0] echo_b_in;

   // decode
   logic [LEN_W-1:0] len_eff;
   logic [7:0]       ch  [NCH];
   logic             chv [NCH];
   logic [3:0]       type_digit;
   logic [9:0]       fa_std;
   logic [9:0]       fa_anim;
   logic [9:0]       fb;
   logic [9:0]       fc;
   logic [9:0]       fd;
   logic             cmd_v_in;
   logic [1:0]       cmd_k_in;
   logic [9:0]       va_in;
   logic [9:0]       vb_in;
   logic [9:0]       vc_in;
   logic [9:0]       vd_in;

   // result register
   logic       rsp_valid_ff;
   logic       echo_v_ff;
   logic [7:0] echo_b_ff;
   logic       cmd_v_ff;
   logic [1:0] cmd_k_ff;
   logic [9:0] va_ff;
   logic [9:0] vb_ff;
   logic [9:0] vc_ff;
   logic [9:0] vd_ff;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff   <= ehcr_pkg::RST_START_CODE;
         ack_code_ff     <= ehcr_pkg::RST_ACK_CODE;
         release_code_ff <= ehcr_pkg::RST_RELEASE_CODE;
         type_bright_ff  <= ehcr_pkg::RST_TYPE_BRIGHTNESS;
         type_color_ff   <= ehcr_pkg::RST_TYPE_COLOR;
         type_speed_ff   <= ehcr_pkg::RST_TYPE_SPEED;
         type_anim_ff    <= ehcr_pkg::RST_TYPE_ANIMATION;
      end else if (csr_write_en) begin
         unique case (csr_index)
            ehcr_pkg::CFG_START_CODE:      start_code_ff   <= csr_wdata;
            ehcr_pkg::CFG_ACK_CODE:        ack_code_ff     <= csr_wdata;
            ehcr_pkg::CFG_RELEASE_CODE:    release_code_ff <= csr_wdata;
            ehcr_pkg::CFG_TYPE_BRIGHTNESS: type_bright_ff  <= csr_wdata[3:0];
            ehcr_pkg::CFG_TYPE_COLOR:      type_color_ff   <= csr_wdata[3:0];
            ehcr_pkg::CFG_TYPE_SPEED:      type_speed_ff   <= csr_wdata[3:0];
            ehcr_pkg::CFG_TYPE_ANIMATION:  type_anim_ff    <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         ehcr_pkg::PH_START: begin
            if (in_byte_ff == start_code_ff) phase_in = ehcr_pkg::PH_READ;
         end
         ehcr_pkg::PH_READ: begin
            if (in_byte_ff != start_code_ff) phase_in = ehcr_pkg::PH_WRITE;
         end
         ehcr_pkg::PH_WRITE: begin
            if (in_byte_ff == ack_code_ff) begin
               phase_in = ehcr_pkg::PH_ACK;
            end else if (in_byte_ff == release_code_ff) begin
               phase_in = ehcr_pkg::PH_START;
            end
         end
         ehcr_pkg::PH_ACK: begin
            if (in_byte_ff != ack_code_ff) phase_in = ehcr_pkg::PH_WRITE;
         end
         default: phase_in = ehcr_pkg::PH_READ;
      endcase
   end

   // per-phase actions and echo
   always_comb begin
      hold_en   = 1'b0;
      append_en = 1'b0;
      clear_en  = 1'b0;
      decode_en = 1'b0;
      echo_v_in = 1'b1;
      echo_b_in = in_byte_ff;
      unique case (phase_ff)
         ehcr_pkg::PH_START: begin
            if (in_byte_ff == start_code_ff) begin
               clear_en = 1'b1;
            end else if (in_byte_ff != release_code_ff) begin
               echo_v_in = 1'b0;
               echo_b_in = 8'd0;
            end
         end
         ehcr_pkg::PH_READ: begin
            if (in_byte_ff != start_code_ff) hold_en = 1'b1;
         end
         ehcr_pkg::PH_WRITE: begin
            if (in_byte_ff == ack_code_ff) begin
               append_en = 1'b1;
            end else if (in_byte_ff == release_code_ff) begin
               append_en = 1'b1;
               decode_en = 1'b1;
               clear_en  = 1'b1;
            end else begin
               echo_b_in = held_ff;
            end
         end
         ehcr_pkg::PH_ACK: begin
            if (in_byte_ff != ack_code_ff) hold_en = 1'b1;
         end
         default: ;
      endcase
   end

   // message view with the held char appended
   assign len_eff = (len_ff < LEN_W'(MSG_DEPTH)) ? len_ff + LEN_W'(1) : len_ff;

   always_comb begin
      for (int p = 0; p < NCH; p++) begin
         ch[p]  = (LEN_W'(p) < len_ff) ? msg_ff[p] : held_ff;
         chv[p] = LEN_W'(p) < len_eff;
      end
   end

   assign type_digit = 4'(ehcr_pkg::field_val(ch[0], 8'd0, 8'd0, chv[0], 1'b0, 1'b0));
   assign fa_std  = ehcr_pkg::field_val(ch[1], ch[2], ch[3], chv[1], chv[2], chv[3]);
   assign fa_anim = ehcr_pkg::field_val(ch[1], 8'd0, 8'd0, chv[1], 1'b0, 1'b0);
   assign fb = ehcr_pkg::field_val(ch[4], ch[5], ch[6], chv[4], chv[5], chv[6]);
   assign fc = ehcr_pkg::field_val(ch[7], ch[8], ch[9], chv[7], chv[8], chv[9]);
   assign fd = ehcr_pkg::field_val(ch[10], ch[11], ch[12], chv[10], chv[11], chv[12]);

   always_comb begin
      cmd_v_in = 1'b0;
      cmd_k_in = ehcr_pkg::KIND_BRIGHTNESS;
      va_in    = 10'd0;
      vb_in    = 10'd0;
      vc_in    = 10'd0;
      vd_in    = 10'd0;
      if (decode_en) begin
         if (type_digit == type_bright_ff) begin
            cmd_v_in = 1'b1;
            cmd_k_in = ehcr_pkg::KIND_BRIGHTNESS;
            va_in    = fa_std;
         end else if (type_digit == type_color_ff) begin
            cmd_v_in = 1'b1;
            cmd_k_in = ehcr_pkg::KIND_COLOR;
            va_in    = fa_std;
            vb_in    = fb;
            vc_in    = fc;
            vd_in    = fd;
         end else if (type_digit == type_speed_ff) begin
            cmd_v_in = 1'b1;
            cmd_k_in = ehcr_pkg::KIND_SPEED;
            va_in    = fa_std;
         end else if (type_digit == type_anim_ff) begin
            cmd_v_in = 1'b1;
            cmd_k_in = ehcr_pkg::KIND_ANIMATION;
            va_in    = fa_anim;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ehcr_pkg::PH_READ;
         held_ff  <= 8'd0;
         len_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         if (hold_en) held_ff <= in_byte_ff;
         if (clear_en) begin
            len_ff <= '0;
         end else if (append_en && (len_ff < LEN_W'(MSG_DEPTH))) begin
            len_ff <= len_ff + LEN_W'(1);
         end
      end
   end

   // only the leading characters are ever decoded; later ones only count
   always_ff @(posedge clock) begin
      for (int i = 0; i < NCH; i++) begin
         if (advance && append_en && (len_ff == LEN_W'(i))) begin
            msg_ff[i] <= held_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         echo_v_ff <= echo_v_in;
         echo_b_ff <= echo_b_in;
         cmd_v_ff  <= cmd_v_in;
         cmd_k_ff  <= cmd_k_in;
         va_ff     <= va_in;
         vb_ff     <= vb_in;
         vc_ff     <= vc_in;
         vd_ff     <= vd_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_echo_valid = echo_v_ff;
   assign rsp_echo_byte  = echo_b_ff;
   assign rsp_cmd_valid  = cmd_v_ff;
   assign rsp_cmd_kind   = cmd_k_ff;
   assign rsp_value_a    = va_ff;
   assign rsp_value_b    = vb_ff;
   assign rsp_value_c    = vc_ff;
   assign rsp_value_d    = vd_ff;

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MSG_DEPTH))
      else $error("message length past depth");

   a_decode_ends_msg: assert property (@(posedge clock) disable iff (reset)
      advance && cmd_v_in |=> phase_ff == ehcr_pkg::PH_START && len_ff == '0)
      else $error("command issued without closing the message");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input word lost");

   a_cmd_has_echo: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cmd_valid |-> rsp_echo_valid)
      else $error("command without release echo");

   a_extra_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_cmd_valid && rsp_cmd_kind == ehcr_pkg::KIND_COLOR)
      |-> rsp_value_b == 10'd0 && rsp_value_c == 10'd0 && rsp_value_d == 10'd0)
      else $error("color fields set outside color command");

endmodule

// ----- tb/sv/echo_handshake_command_receiver_core_tb.sv -----
// Testbench for echo_handshake_command_receiver_core: echo, message collection and command decode.
// Holds a self-checking predictor class and the drivers; depends on ehcr_pkg and the core.
`timescale 1ns / 1ps

typedef struct packed {
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic       cmd_valid;
   logic [1:0] cmd_kind;
   logic [9:0] value_a;
   logic [9:0] value_b;
   logic [9:0] value_c;
   logic [9:0] value_d;
} echo_result_type;

class echo_command_board;
   logic [7:0]          start_code;
   logic [7:0]          ack_code;
   logic [7:0]          release_code;
   logic [3:0]          type_bright;
   logic [3:0]          type_color;
   logic [3:0]          type_speed;
   logic [3:0]          type_anim;
   ehcr_pkg::phase_type phase;
   logic [7:0]          held;
   logic [7:0]          store [0:ehcr_pkg::MSG_DEPTH_DEF-1];
   int unsigned         length;
   echo_result_type     expected_replies[$];
   int                  errors;
   int                  checked;
   int                  dropped;
   int                  kind_count [0:3];

   function new();
      errors = 0;
      checked = 0;
      dropped = 0;
      foreach (kind_count[k]) kind_count[k] = 0;
      restart();
   endfunction

   function void restart();
      start_code   = ehcr_pkg::RST_START_CODE;
      ack_code     = ehcr_pkg::RST_ACK_CODE;
      release_code = ehcr_pkg::RST_RELEASE_CODE;
      type_bright  = ehcr_pkg::RST_TYPE_BRIGHTNESS;
      type_color   = ehcr_pkg::RST_TYPE_COLOR;
      type_speed   = ehcr_pkg::RST_TYPE_SPEED;
      type_anim    = ehcr_pkg::RST_TYPE_ANIMATION;
      phase        = ehcr_pkg::PH_READ;
      held         = 8'd0;
      length       = 0;
      expected_replies.delete();
   endfunction

   function void write_register(logic [ehcr_pkg::CSR_IDX_W-1:0] idx,
                                logic [ehcr_pkg::CSR_DATA_W-1:0] d);
      case (idx)
         ehcr_pkg::CFG_START_CODE:      start_code   = d;
         ehcr_pkg::CFG_ACK_CODE:        ack_code     = d;
         ehcr_pkg::CFG_RELEASE_CODE:    release_code = d;
         ehcr_pkg::CFG_TYPE_BRIGHTNESS: type_bright  = d[3:0];
         ehcr_pkg::CFG_TYPE_COLOR:      type_color   = d[3:0];
         ehcr_pkg::CFG_TYPE_SPEED:      type_speed   = d[3:0];
         ehcr_pkg::CFG_TYPE_ANIMATION:  type_anim    = d[3:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_replies.size();
   endfunction

   function void append_held();
      if (length < ehcr_pkg::MSG_DEPTH_DEF) begin
         store[length] = held;
         length++;
      end else begin
         dropped++;
      end
   endfunction

   // leading decimal digits of positions [first, last), clipped to the message
   function logic [9:0] decimal_field(int unsigned first, int unsigned last);
      int unsigned v;
      int unsigned i;
      bit          going;
      v = 0;
      going = 1'b1;
      if (last > length) last = length;
      for (i = first; i < last && going; i++) begin
         if (store[i] >= ehcr_pkg::CHAR_ZERO && store[i] <= ehcr_pkg::CHAR_NINE) begin
            v = v * 10 + (store[i] - ehcr_pkg::CHAR_ZERO);
         end else begin
            going = 1'b0;
         end
      end
      return v[9:0];
   endfunction

   function void decode_into(ref echo_result_type r);
      int unsigned t;
      t = decimal_field(0, 1);
      if (t == type_bright) begin
         r.cmd_valid = 1'b1;
         r.cmd_kind  = ehcr_pkg::KIND_BRIGHTNESS;
         r.value_a   = decimal_field(1, 4);
      end else if (t == type_color) begin
         r.cmd_valid = 1'b1;
         r.cmd_kind  = ehcr_pkg::KIND_COLOR;
         r.value_a   = decimal_field(1, 4);
         r.value_b   = decimal_field(4, 7);
         r.value_c   = decimal_field(7, 10);
         r.value_d   = decimal_field(10, 13);
      end else if (t == type_speed) begin
         r.cmd_valid = 1'b1;
         r.cmd_kind  = ehcr_pkg::KIND_SPEED;
         r.value_a   = decimal_field(1, 4);
      end else if (t == type_anim) begin
         r.cmd_valid = 1'b1;
         r.cmd_kind  = ehcr_pkg::KIND_ANIMATION;
         r.value_a   = decimal_field(1, 2);
      end
      if (r.cmd_valid) kind_count[r.cmd_kind]++;
   endfunction

   function void take_word(logic [7:0] b);
      echo_result_type r;
      r = '0;
      r.echo_valid = 1'b1;
      case (phase)
         ehcr_pkg::PH_START: begin
            if (b == start_code) begin
               length = 0;
               r.echo_byte = start_code;
               phase = ehcr_pkg::PH_READ;
            end else if (b == release_code) begin
               r.echo_byte = release_code;
            end else begin
               r.echo_valid = 1'b0;
            end
         end
         ehcr_pkg::PH_READ: begin
            if (b == start_code) begin
               r.echo_byte = start_code;
            end else begin
               held = b;
               r.echo_byte = b;
               phase = ehcr_pkg::PH_WRITE;
            end
         end
         ehcr_pkg::PH_WRITE: begin
            if (b == ack_code) begin
               append_held();
               r.echo_byte = ack_code;
               phase = ehcr_pkg::PH_ACK;
            end else if (b == release_code) begin
               append_held();
               decode_into(r);
               length = 0;
               r.echo_byte = release_code;
               phase = ehcr_pkg::PH_START;
            end else begin
               r.echo_byte = held;
            end
         end
         default: begin
            if (b == ack_code) begin
               r.echo_byte = ack_code;
            end else begin
               held = b;
               r.echo_byte = b;
               phase = ehcr_pkg::PH_WRITE;
            end
         end
      endcase
      expected_replies.push_back(r);
   endfunction

   function void field_check(string name, int unsigned e, int unsigned a);
      if (e != a) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
         errors++;
      end
   endfunction

   function void check_word(echo_result_type got);
      echo_result_type e;
      if (expected_replies.size() == 0) begin
         $display("%0t: result with nothing expected, got echo %0d/%0d cmd %0d/%0d",
                  $time, got.echo_valid, got.echo_byte, got.cmd_valid, got.cmd_kind);
         errors++;
         return;
      end
      e = expected_replies.pop_front();
      checked++;
      field_check("echo_valid", e.echo_valid, got.echo_valid);
      field_check("echo_byte", e.echo_byte, got.echo_byte);
      field_check("cmd_valid", e.cmd_valid, got.cmd_valid);
      field_check("cmd_kind", e.cmd_kind, got.cmd_kind);
      field_check("value_a", e.value_a, got.value_a);
      field_check("value_b", e.value_b, got.value_b);
      field_check("value_c", e.value_c, got.value_c);
      field_check("value_d", e.value_d, got.value_d);
   endfunction
endclass

module echo_handshake_command_receiver_core_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 60;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [7:0]                      req_rx_byte = 8'd0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_echo_valid;
   logic [7:0]                      rsp_echo_byte;
   logic                            rsp_cmd_valid;
   logic [1:0]                      rsp_cmd_kind;
   logic [9:0]                      rsp_value_a;
   logic [9:0]                      rsp_value_b;
   logic [9:0]                      rsp_value_c;
   logic [9:0]                      rsp_value_d;
   logic                            csr_write_en = 1'b0;
   logic [ehcr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [ehcr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   echo_command_board sb;
   echo_result_type   got;
   logic [7:0]        msg_buf [0:23];
   int                cycle_count = 0;
   int                words_sent = 0;
   int                burst_left = 0;
   int                settings_used = 1;
   int                holds_asked = 0;
   int                holds_done = 0;
   int                hold_left = 0;
   logic [15:0]       ready_pattern = 16'hFFFF;
   int                pattern_age = 0;

   echo_handshake_command_receiver_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_echo_valid (rsp_echo_valid),
      .rsp_echo_byte  (rsp_echo_byte),
      .rsp_cmd_valid  (rsp_cmd_valid),
      .rsp_cmd_kind   (rsp_cmd_kind),
      .rsp_value_a    (rsp_value_a),
      .rsp_value_b    (rsp_value_b),
      .rsp_value_c    (rsp_value_c),
      .rsp_value_d    (rsp_value_d),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         sb.restart();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.echo_valid = rsp_echo_valid;
            got.echo_byte  = rsp_echo_byte;
            got.cmd_valid  = rsp_cmd_valid;
            got.cmd_kind   = rsp_cmd_kind;
            got.value_a    = rsp_value_a;
            got.value_b    = rsp_value_b;
            got.value_c    = rsp_value_c;
            got.value_d    = rsp_value_d;
            sb.check_word(got);
         end
         if (req_valid && req_ready) sb.take_word(req_rx_byte);
         if (csr_write_en) sb.write_register(csr_index, csr_wdata);
      end
   end

   // receiver: rotating stall pattern, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (holds_done < holds_asked) begin
         rsp_ready <= 1'b0;
         hold_left = HOLD_CYCLES - 1;
         holds_done++;
      end else begin
         if (pattern_age == 0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
            pattern_age = $urandom_range(16, 80);
         end
         pattern_age--;
         rsp_ready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   function automatic logic [7:0] other_byte(input logic [7:0] x, input logic [7:0] y);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == x || c == y);
      return c;
   endfunction

   task automatic send_word(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      burst_left--;
      words_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [7:0] s, input logic [7:0] a, input logic [7:0] r,
                                input logic [3:0] tb, input logic [3:0] tc,
                                input logic [3:0] ts, input logic [3:0] ta);
      logic [ehcr_pkg::CSR_IDX_W-1:0]  idx [0:6];
      logic [ehcr_pkg::CSR_DATA_W-1:0] val [0:6];
      int i;
      idx[0] = ehcr_pkg::CFG_START_CODE;      val[0] = s;
      idx[1] = ehcr_pkg::CFG_ACK_CODE;        val[1] = a;
      idx[2] = ehcr_pkg::CFG_RELEASE_CODE;    val[2] = r;
      // upper nibble of the type registers is junk and must be ignored
      idx[3] = ehcr_pkg::CFG_TYPE_BRIGHTNESS; val[3] = {4'($urandom), tb};
      idx[4] = ehcr_pkg::CFG_TYPE_COLOR;      val[4] = {4'($urandom), tc};
      idx[5] = ehcr_pkg::CFG_TYPE_SPEED;      val[5] = {4'($urandom), ts};
      idx[6] = ehcr_pkg::CFG_TYPE_ANIMATION;  val[6] = {4'($urandom), ta};
      wait_drained();
      for (i = 0; i < 7; i++) begin
         @(negedge clock);
         csr_write_en <= 1'b1;
         csr_index    <= idx[i];
         csr_wdata    <= val[i];
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // start, then each char acked; the last one released when finish is set
   task automatic send_message(input int n, input bit finish);
      int i;
      send_word(sb.start_code);
      for (i = 0; i < n; i++) begin
         send_word(msg_buf[i]);
         if ($urandom_range(0, 9) == 0) send_word(other_byte(sb.ack_code, sb.release_code));
         send_word((finish && i == n - 1) ? sb.release_code : sb.ack_code);
      end
   endtask

   task automatic send_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) msg_buf[i] = s[i];
      send_message(s.len(), 1'b1);
   endtask

   task automatic send_random_message(input bit finish);
      int n;
      int i;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 13);
      case ($urandom_range(0, 9))
         0, 1:    msg_buf[0] = ehcr_pkg::CHAR_ZERO + sb.type_bright;
         2, 3:    msg_buf[0] = ehcr_pkg::CHAR_ZERO + sb.type_color;
         4, 5:    msg_buf[0] = ehcr_pkg::CHAR_ZERO + sb.type_speed;
         6, 7:    msg_buf[0] = ehcr_pkg::CHAR_ZERO + sb.type_anim;
         8:       msg_buf[0] = ehcr_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
         default: msg_buf[0] = 8'($urandom_range(0, 255));
      endcase
      for (i = 1; i < n; i++) begin
         msg_buf[i] = ($urandom_range(0, 11) == 0) ? 8'($urandom_range(0, 255))
                                                   : ehcr_pkg::CHAR_ZERO
                                                     + 8'($urandom_range(0, 9));
      end
      for (i = 0; i < n; i++) begin
         if (msg_buf[i] == sb.start_code || msg_buf[i] == sb.ack_code)
            msg_buf[i] = other_byte(sb.start_code, sb.ack_code);
      end
      send_message(n, finish);
   endtask

   task automatic run_traffic(input int target);
      int first;
      int r;
      first = words_sent;
      while (words_sent - first < target) begin
         r = $urandom_range(0, 19);
         if (r < 14) begin
            send_random_message(1'b1);
         end else if (r < 17) begin
            repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 255)));
         end else if (r < 19) begin
            send_random_message(1'b0);
         end else begin
            wait_drained();
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme bytes, unmatched type, release in start phase, brightness, animation and color
      send_word(8'h00);
      send_word(8'hFF);
      send_word(ehcr_pkg::RST_RELEASE_CODE);
      send_word(8'hAA);
      send_word(ehcr_pkg::RST_RELEASE_CODE);
      send_text("1999");
      send_text("49");
      send_text("2");
      send_text("7");

      holds_asked++;
      run_traffic(120);

      apply_setting(8'h00, 8'hFF, 8'h80, 4'd0, 4'd9, 4'd5, 4'd7);
      run_traffic(100);
      apply_setting(8'hFF, 8'h00, 8'h01, 4'd9, 4'd9, 4'd0, 4'd0);
      holds_asked++;
      run_traffic(100);
      // start and release share a code; brightness and speed share a type
      apply_setting(8'h10, 8'h20, 8'h10, 4'd3, 4'd2, 4'd3, 4'd8);
      run_traffic(80);
      // ack and release share a code, so messages never close
      apply_setting(8'h7E, 8'h33, 8'h33, 4'd1, 4'd2, 4'd3, 4'd4);
      run_traffic(30);
      apply_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                    4'($urandom_range(0, 9)));
      run_traffic(80);

      wait_drained();
      repeat (8) @(posedge clock);
      if (sb.pending() > 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
         sb.errors++;
      end
      $display("Covered %0d words over %0d register settings, %0d results checked",
               words_sent, settings_used, sb.checked);
      $display("Commands: %0d brightness, %0d color, %0d speed, %0d animation; %0d chars dropped",
               sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
               sb.dropped);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
